/* rtl/core/ryc422_pkg.sv */
// Package for the RGB pixel pair to YCbCr 4:2:2 converter: payload types and constants.
package ryc422_pkg;

  // Fixed-point format of the color matrix
  localparam int FracBits = 16;
  localparam int CoefW    = 18;

  // Luma weights (value * 65536, truncated toward zero)
  localparam logic signed [CoefW-1:0] KYR = 18'sd19595;
  localparam logic signed [CoefW-1:0] KYG = 18'sd38469;
  localparam logic signed [CoefW-1:0] KYB = 18'sd7471;
  // Cb weights
  localparam logic signed [CoefW-1:0] KUR = -18'sd11075;
  localparam logic signed [CoefW-1:0] KUG = -18'sd21692;
  localparam logic signed [CoefW-1:0] KUB = 18'sd32768;
  // Cr weights
  localparam logic signed [CoefW-1:0] KVR = 18'sd32768;
  localparam logic signed [CoefW-1:0] KVG = -18'sd27459;
  localparam logic signed [CoefW-1:0] KVB = -18'sd5308;

  // Offsets and clamp bounds
  localparam int LumaOffset   = 16;
  localparam int ChromaOffset = 128;
  localparam int LumaMin      = 16;
  localparam int LumaMax      = 235;
  localparam int ChromaMin    = 16;
  localparam int ChromaMax    = 240;

  // Pipeline depth from start to result strobe
  localparam int Latency = 4;

  // One request: two horizontally adjacent RGB pixels
  typedef struct packed {
    logic [7:0] first_red;
    logic [7:0] first_green;
    logic [7:0] first_blue;
    logic [7:0] second_red;
    logic [7:0] second_green;
    logic [7:0] second_blue;
  } pix_req_t;

  // One result: packed Y1, Cb, Y2, Cr from the most significant byte down
  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] chroma_blue;
    logic [7:0] luma_second;
    logic [7:0] chroma_red;
  } ycc_res_t;

endpackage

/* rtl/core/ryc422_chan.sv */
// One color channel: weighted sum of R, G, B, floor shift, offset and clamp in three stages.
module ryc422_chan
  import ryc422_pkg::*;
#(
  parameter logic signed [CoefW-1:0] CoefR  = KYR,
  parameter logic signed [CoefW-1:0] CoefG  = KYG,
  parameter logic signed [CoefW-1:0] CoefB  = KYB,
  parameter int                      Offset = LumaOffset,
  parameter int                      MinVal = LumaMin,
  parameter int                      MaxVal = LumaMax
) (
  input  logic       clk_i,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  output logic [7:0] value_o
);

  localparam int ProdW  = CoefW + 9;
  localparam int SumW   = ProdW + 2;
  localparam int ShiftW = SumW - FracBits;
  localparam int ValW   = ShiftW + 1;

  localparam logic signed [ValW-1:0] OffS = ValW'(Offset);
  localparam logic signed [ValW-1:0] LoS  = ValW'(MinVal);
  localparam logic signed [ValW-1:0] HiS  = ValW'(MaxVal);

  logic signed [ProdW-1:0]  prod_r_d, prod_g_d, prod_b_d;
  logic signed [ProdW-1:0]  prod_r_q, prod_g_q, prod_b_q;
  logic signed [SumW-1:0]   sum_d;
  logic signed [ShiftW-1:0] shift_d, shift_q;
  logic signed [ValW-1:0]   val_d;
  logic [7:0]               value_d, value_q;

  // Multiply each component by its weight
  always_comb begin
    prod_r_d = ProdW'($signed({1'b0, red_i}))   * ProdW'(CoefR);
    prod_g_d = ProdW'($signed({1'b0, green_i})) * ProdW'(CoefG);
    prod_b_d = ProdW'($signed({1'b0, blue_i}))  * ProdW'(CoefB);
  end

  // Sum the products and drop the fraction, rounding toward minus infinity
  always_comb begin
    sum_d   = SumW'(prod_r_q) + SumW'(prod_g_q) + SumW'(prod_b_q);
    shift_d = sum_d[SumW-1:FracBits];
  end

  // Add the offset and clamp into range
  always_comb begin
    val_d = ValW'(shift_q) + OffS;
    if (val_d < LoS) begin
      value_d = LoS[7:0];
    end else if (val_d > HiS) begin
      value_d = HiS[7:0];
    end else begin
      value_d = val_d[7:0];
    end
  end

  // Advance the data stages every cycle
  always_ff @(posedge clk_i) begin
    prod_r_q <= prod_r_d;
    prod_g_q <= prod_g_d;
    prod_b_q <= prod_b_d;
    shift_q  <= shift_d;
    value_q  <= value_d;
  end

  assign value_o = value_q;

endmodule

/* rtl/core/rgb_pair_to_ycbcr422_core.sv */
// Top level of the RGB pixel pair to YCbCr 4:2:2 converter.
//
//   port              dir  role
//   start / req_i     in   request: two RGB pixels, taken when start is high and busy low
//   result_valid_o /  out  one-cycle strobe with packed Y1, Cb, Y2, Cr
//     result_o
//
// A request is taken in every cycle; busy stays low.
// Each result passes one input stage (pixel average), then the multiply,
// sum-and-shift and clamp stages in each channel unit.
// Reset clears only the valid bits that travel with the data.
// The receiver cannot stall, so the pipeline never holds.
module rgb_pair_to_ycbcr422_core
  import ryc422_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  pix_req_t req_i,
  output logic     result_valid_o,
  output ycc_res_t result_o
);

  logic [Latency-1:0] valid_d, valid_q;
  pix_req_t           pix_q;
  logic [7:0]         avg_r_d, avg_g_d, avg_b_d;
  logic [7:0]         avg_r_q, avg_g_q, avg_b_q;
  logic [8:0]         sum_r, sum_g, sum_b;

  assign busy = 1'b0;

  // Average the two pixels, truncating
  always_comb begin
    sum_r   = {1'b0, req_i.first_red}   + {1'b0, req_i.second_red};
    sum_g   = {1'b0, req_i.first_green} + {1'b0, req_i.second_green};
    sum_b   = {1'b0, req_i.first_blue}  + {1'b0, req_i.second_blue};
    avg_r_d = sum_r[8:1];
    avg_g_d = sum_g[8:1];
    avg_b_d = sum_b[8:1];
  end

  // Capture the request and its average
  always_ff @(posedge clk_i) begin
    pix_q   <= req_i;
    avg_r_q <= avg_r_d;
    avg_g_q <= avg_g_d;
    avg_b_q <= avg_b_d;
  end

  // Shift the valid bits along with the data
  assign valid_d = {valid_q[Latency-2:0], start & ~busy};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  ryc422_chan #(
    .CoefR(KYR), .CoefG(KYG), .CoefB(KYB),
    .Offset(LumaOffset), .MinVal(LumaMin), .MaxVal(LumaMax)
  ) u_luma_first (
    .clk_i  (clk_i),
    .red_i  (pix_q.first_red),
    .green_i(pix_q.first_green),
    .blue_i (pix_q.first_blue),
    .value_o(result_o.luma_first)
  );

  ryc422_chan #(
    .CoefR(KUR), .CoefG(KUG), .CoefB(KUB),
    .Offset(ChromaOffset), .MinVal(ChromaMin), .MaxVal(ChromaMax)
  ) u_chroma_blue (
    .clk_i  (clk_i),
    .red_i  (avg_r_q),
    .green_i(avg_g_q),
    .blue_i (avg_b_q),
    .value_o(result_o.chroma_blue)
  );

  ryc422_chan #(
    .CoefR(KYR), .CoefG(KYG), .CoefB(KYB),
    .Offset(LumaOffset), .MinVal(LumaMin), .MaxVal(LumaMax)
  ) u_luma_second (
    .clk_i  (clk_i),
    .red_i  (pix_q.second_red),
    .green_i(pix_q.second_green),
    .blue_i (pix_q.second_blue),
    .value_o(result_o.luma_second)
  );

  ryc422_chan #(
    .CoefR(KVR), .CoefG(KVG), .CoefB(KVB),
    .Offset(ChromaOffset), .MinVal(ChromaMin), .MaxVal(ChromaMax)
  ) u_chroma_red (
    .clk_i  (clk_i),
    .red_i  (avg_r_q),
    .green_i(avg_g_q),
    .blue_i (avg_b_q),
    .value_o(result_o.chroma_red)
  );

  assign result_valid_o = valid_q[Latency-1];

endmodule

/* verif/ycc422_checker.sv */
// Checker for the RGB pair to YCbCr 4:2:2 converter: watches requests and results and compares.
`timescale 1ns / 100ps

module ycc422_checker
  import ryc422_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  logic     busy_i,
  input  pix_req_t req_i,
  input  logic     result_valid_i,
  input  ycc_res_t result_i,
  output int       mismatch_count_o,
  output int       pending_count_o
);

  // Conversions still owed by the block, oldest first
  ycc_res_t owed_ycc[$];

  // Weighted sum of one color, shifted down with rounding toward minus infinity
  function automatic int weigh_rgb(int kr, int kg, int kb, int r, int g, int b);
    int acc;
    acc = kr * r + kg * g + kb * b;
    return acc >>> FracBits;
  endfunction

  function automatic logic [7:0] clamp_byte(int v, int lo, int hi);
    if (v < lo) begin
      v = lo;
    end
    if (v > hi) begin
      v = hi;
    end
    return v[7:0];
  endfunction

  // Convert one pixel pair: luma per pixel, chroma from the truncated average
  function automatic ycc_res_t convert_pair(pix_req_t p);
    ycc_res_t y;
    int ra, ga, ba;
    ra = (int'(p.first_red) + int'(p.second_red)) >> 1;
    ga = (int'(p.first_green) + int'(p.second_green)) >> 1;
    ba = (int'(p.first_blue) + int'(p.second_blue)) >> 1;
    y.luma_first  = clamp_byte(weigh_rgb(KYR, KYG, KYB, p.first_red, p.first_green,
                                         p.first_blue) + LumaOffset, LumaMin, LumaMax);
    y.luma_second = clamp_byte(weigh_rgb(KYR, KYG, KYB, p.second_red, p.second_green,
                                         p.second_blue) + LumaOffset, LumaMin, LumaMax);
    y.chroma_blue = clamp_byte(weigh_rgb(KUR, KUG, KUB, ra, ga, ba) + ChromaOffset,
                               ChromaMin, ChromaMax);
    y.chroma_red  = clamp_byte(weigh_rgb(KVR, KVG, KVB, ra, ga, ba) + ChromaOffset,
                               ChromaMin, ChromaMax);
    return y;
  endfunction

  function automatic int field_diff(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Predict on each accepted request, then compare each result strobe with the oldest
  always @(posedge clk_i or negedge rst_ni) begin
    ycc_res_t want;
    int bad;
    if (!rst_ni) begin
      owed_ycc.delete();
      mismatch_count_o <= 0;
    end else begin
      if (start_i && !busy_i) begin
        owed_ycc.push_back(convert_pair(req_i));
      end
      if (result_valid_i) begin
        if (owed_ycc.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, result_i);
          mismatch_count_o <= mismatch_count_o + 1;
        end else begin
          want = owed_ycc.pop_front();
          bad = field_diff("luma_first", want.luma_first, result_i.luma_first)
              + field_diff("chroma_blue", want.chroma_blue, result_i.chroma_blue)
              + field_diff("luma_second", want.luma_second, result_i.luma_second)
              + field_diff("chroma_red", want.chroma_red, result_i.chroma_red);
          if (bad != 0) begin
            mismatch_count_o <= mismatch_count_o + 1;
          end
        end
      end
    end
  end

  assign pending_count_o = owed_ycc.size();

endmodule

/* verif/testbench.sv */
// Top of the converter testbench: clock, reset, pixel-pair stimulus and the verdict.
`timescale 1ns / 100ps

module testbench;
  import ryc422_pkg::*;

  localparam int RandomPairs = 1750;
  localparam int CycleLimit  = 200000;
  localparam int DrainLimit  = 2000;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  pix_req_t req_i;
  logic     result_valid_o;
  ycc_res_t result_o;
  int       mismatch_count;
  int       pending_count;
  int       cycle_count = 0;
  int       idle_pct;

  rgb_pair_to_ycbcr422_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  ycc422_checker checker_inst (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_i           (busy),
    .req_i            (req_i),
    .result_valid_i   (result_valid_o),
    .result_i         (result_o),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic pix_req_t make_pair(logic [7:0] r1, logic [7:0] g1, logic [7:0] b1,
                                         logic [7:0] r2, logic [7:0] g2, logic [7:0] b2);
    pix_req_t p;
    p.first_red    = r1;
    p.first_green  = g1;
    p.first_blue   = b1;
    p.second_red   = r2;
    p.second_green = g2;
    p.second_blue  = b2;
    return p;
  endfunction

  // Lean toward the rails so that clamping is hit often
  function automatic logic [7:0] pick_component();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'($urandom_range(255, 240));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic pix_req_t random_pair();
    pix_req_t p;
    p = make_pair(pick_component(), pick_component(), pick_component(),
                  pick_component(), pick_component(), pick_component());
    // Sometimes repeat the left pixel for the single-pixel case
    if ($urandom_range(7) == 0) begin
      p.second_red   = p.first_red;
      p.second_green = p.first_green;
      p.second_blue  = p.first_blue;
    end
    return p;
  endfunction

  // Idle at random, then present one request and hold it until taken
  task automatic send_pair(pix_req_t p);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= p;
    @(negedge clk_i);
    while (busy) begin
      @(negedge clk_i);
    end
    @(posedge clk_i);
  endtask

  initial begin
    logic [7:0] shade;
    int waited;
    idle_pct    = 14;
    rst_ni      = 1'b0;
    start       = 1'b0;
    req_i       = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: black, white, primaries, clamp rails, odd averages, single pixels
    send_pair(make_pair(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    send_pair(make_pair(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
    send_pair(make_pair(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0));
    send_pair(make_pair(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255));
    send_pair(make_pair(8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0));
    send_pair(make_pair(8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0));
    send_pair(make_pair(8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255));
    send_pair(make_pair(8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0));
    send_pair(make_pair(8'd0, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255));
    send_pair(make_pair(8'd255, 8'd0, 8'd255, 8'd255, 8'd0, 8'd255));
    send_pair(make_pair(8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    send_pair(make_pair(8'd1, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0));
    send_pair(make_pair(8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128));
    send_pair(make_pair(8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd255));
    send_pair(make_pair(8'd254, 8'd255, 8'd253, 8'd255, 8'd254, 8'd255));
    send_pair(make_pair(8'd170, 8'd85, 8'd170, 8'd85, 8'd170, 8'd85));
    send_pair(make_pair(8'd0, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0));
    send_pair(make_pair(8'd1, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0));
    repeat (3) begin
      shade = 8'($urandom_range(255));
      send_pair(make_pair(shade, 8'($urandom_range(255)), 8'd255 - shade,
                          shade, 8'd255, 8'd0));
    end

    // Random pairs in three phases: light sender gaps, heavy gaps, back to back
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 14 : (phase == 1) ? 79 : 0;
      for (int n = 0; n < RandomPairs / 3; n++) begin
        send_pair(random_pair());
      end
    end
    start <= 1'b0;

    // Drain the pipeline, then allow a few extra cycles for stray strobes
    waited = 0;
    while (pending_count != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (Latency + 4) @(posedge clk_i);

    if (mismatch_count == 0 && pending_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/ryc422_pkg.sv
rtl/core/ryc422_chan.sv
rtl/core/rgb_pair_to_ycbcr422_core.sv
verif/ycc422_checker.sv
verif/testbench.sv
